// ===== hw/rtl/bbs_pkg.sv =====
// Shared types and constants for the bounding box and sphere unit.
// No dependencies; used by every module under hw/rtl.
package bbs_pkg;

    // Coordinate format: signed Q12.12
    localparam int COORD_WIDTH = 24;
    localparam int NUM_AXES    = 3;
    localparam int AXIS_W      = 2;

    // Square root sizing: sum of three squares and its root
    localparam int SUM_W      = 2 * COORD_WIDTH + 2;
    localparam int ROOT_W     = COORD_WIDTH + 1;
    localparam int REM_W      = ROOT_W + 4;
    localparam int ROOT_STEPS = SUM_W / 2;
    localparam int CNT_W      = $clog2(ROOT_STEPS);

    // Axis select codes for the shared multiplier
    localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

    // Input word: one vertex
    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] pos_x;
        logic signed [COORD_WIDTH-1:0] pos_y;
        logic signed [COORD_WIDTH-1:0] pos_z;
        logic                          end_of_mesh;
    } t_vertex;

    // Output word: one box and sphere per mesh
    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] lo_x;
        logic signed [COORD_WIDTH-1:0] lo_y;
        logic signed [COORD_WIDTH-1:0] lo_z;
        logic signed [COORD_WIDTH-1:0] hi_x;
        logic signed [COORD_WIDTH-1:0] hi_y;
        logic signed [COORD_WIDTH-1:0] hi_z;
        logic signed [COORD_WIDTH-1:0] mid_x;
        logic signed [COORD_WIDTH-1:0] mid_y;
        logic signed [COORD_WIDTH-1:0] mid_z;
        logic        [COORD_WIDTH-1:0] sphere_radius;
    } t_result;

    // Controller states
    typedef enum logic [2:0] {
        ST_ACCUM,
        ST_DIFF,
        ST_SQR,
        ST_RINIT,
        ST_ROOT,
        ST_DONE
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic              box_load;
        logic              box_track;
        logic              diff_en;
        logic              sq_en;
        logic              acc_en;
        logic              root_init;
        logic              root_step;
        logic              out_load;
        logic [AXIS_W-1:0] axis;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic out_busy;
    } t_dp_status;

endpackage

// ===== hw/rtl/bounding_box_and_sphere_unit.sv =====
// Top level of the bounding box and sphere unit: controller plus datapath.
// Depends on bbs_pkg, bbs_ctrl and bbs_datapath.
//
// Vertices (signed Q12.12) are taken one per cycle while a mesh is being
// accumulated; the running per-axis minimum and maximum update in the cycle
// of acceptance. After the vertex flagged end_of_mesh, input ready stays low
// while the unit forms the extents, squares them on the single shared
// squarer, loads the root unit, runs the square root, which produces one
// root bit per cycle, and loads the result word into the output register.
// That load waits while the previous word is still unread; the word is held
// there until taken. Then the next mesh begins; a one-vertex mesh gives a
// zero-size box with radius zero.
module bounding_box_and_sphere_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  bbs_pkg::t_vertex i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output bbs_pkg::t_result o_out_data
);

    bbs_pkg::t_dp_cmd    cmd;
    bbs_pkg::t_dp_status status;

    // Sequencer
    bbs_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_end_of_mesh (i_in_data.end_of_mesh),
        .i_status      (status),
        .o_in_ready    (o_in_ready),
        .o_cmd         (cmd)
    );

    // Arithmetic and result register
    bbs_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_vertex    (i_in_data),
        .i_out_ready (i_out_ready),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== hw/rtl/bbs_datapath.sv =====
// Datapath: running extents, extent differences, shared squarer,
// digit-recurrence square root and the output word register.
// Depends on bbs_pkg.
module bbs_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bbs_pkg::t_dp_cmd   i_cmd,
    input  bbs_pkg::t_vertex   i_vertex,
    input  logic               i_out_ready,
    output bbs_pkg::t_dp_status o_status,
    output logic               o_out_valid,
    output bbs_pkg::t_result   o_out_data
);

    localparam int W   = bbs_pkg::COORD_WIDTH;
    localparam int NA  = bbs_pkg::NUM_AXES;
    localparam int SW  = bbs_pkg::SUM_W;
    localparam int RW  = bbs_pkg::ROOT_W;
    localparam int MW  = bbs_pkg::REM_W;

    logic signed [W-1:0] r_lo [NA];
    logic signed [W-1:0] r_hi [NA];
    logic        [W-1:0] r_d  [NA];
    logic      [2*W-1:0] r_prod;
    logic       [SW-1:0] r_sum;
    logic       [SW-1:0] r_n;
    logic       [MW-1:0] r_rem;
    logic       [RW-1:0] r_root;
    bbs_pkg::t_result    r_out;
    logic                r_out_valid;

    logic signed [W-1:0] pos [NA];
    logic        [W-1:0] d_sel;
    logic      [2*W-1:0] d_ext;
    logic       [MW-1:0] rem_sh;
    logic       [MW-1:0] trial;
    logic        [W-1:0] mid [NA];

    assign pos[0] = i_vertex.pos_x;
    assign pos[1] = i_vertex.pos_y;
    assign pos[2] = i_vertex.pos_z;

    // Running minimum and maximum per axis
    always_ff @(posedge i_clk) begin
        for (int a = 0; a < NA; a++) begin
            if (i_cmd.box_load) begin
                r_lo[a] <= pos[a];
                r_hi[a] <= pos[a];
            end else if (i_cmd.box_track) begin
                if (pos[a] < r_lo[a]) begin
                    r_lo[a] <= pos[a];
                end else if (pos[a] > r_hi[a]) begin
                    r_hi[a] <= pos[a];
                end
            end
        end
    end

    // Extent per axis; always fits W bits unsigned since hi >= lo
    always_ff @(posedge i_clk) begin
        if (i_cmd.diff_en) begin
            for (int a = 0; a < NA; a++) begin
                r_d[a] <= W'(r_hi[a] - r_lo[a]);
            end
        end
    end

    // Axis mux for the shared squarer
    always_comb begin
        case (i_cmd.axis)
            bbs_pkg::AXIS_X: d_sel = r_d[0];
            bbs_pkg::AXIS_Y: d_sel = r_d[1];
            bbs_pkg::AXIS_Z: d_sel = r_d[2];
            default:         d_sel = '0;
        endcase
    end

    assign d_ext = {{W{1'b0}}, d_sel};

    // Square one axis per cycle, accumulate the registered product
    always_ff @(posedge i_clk) begin
        if (i_cmd.sq_en) begin
            r_prod <= d_ext * d_ext;
        end
        if (i_cmd.diff_en) begin
            r_sum <= '0;
        end else if (i_cmd.acc_en) begin
            r_sum <= r_sum + {2'b00, r_prod};
        end
    end

    // Square root: two radicand bits per step, one root bit out
    assign rem_sh = {r_rem[MW-3:0], r_n[SW-1:SW-2]};
    assign trial  = {3'b000, r_root[RW-2:0], 2'b01};

    always_ff @(posedge i_clk) begin
        if (i_cmd.root_init) begin
            r_n    <= r_sum;
            r_rem  <= '0;
            r_root <= '0;
        end else if (i_cmd.root_step) begin
            r_n <= {r_n[SW-3:0], 2'b00};
            if (rem_sh >= trial) begin
                r_rem  <= rem_sh - trial;
                r_root <= {r_root[RW-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh;
                r_root <= {r_root[RW-2:0], 1'b0};
            end
        end
    end

    // Center: half extent, floored, plus minimum
    always_comb begin
        for (int a = 0; a < NA; a++) begin
            mid[a] = {1'b0, r_d[a][W-1:1]} + r_lo[a];
        end
    end

    // Output word register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.lo_x          <= r_lo[0];
            r_out.lo_y          <= r_lo[1];
            r_out.lo_z          <= r_lo[2];
            r_out.hi_x          <= r_hi[0];
            r_out.hi_y          <= r_hi[1];
            r_out.hi_z          <= r_hi[2];
            r_out.mid_x         <= mid[0];
            r_out.mid_y         <= mid[1];
            r_out.mid_z         <= mid[2];
            r_out.sphere_radius <= r_root[RW-1:1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.out_busy = r_out_valid & ~i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out;

endmodule

// ===== hw/rtl/bbs_ctrl.sv =====
// Controller: sequences accumulate, extent, squaring, square root and
// output load for each mesh. Depends on bbs_pkg.
module bbs_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_end_of_mesh,
    input  bbs_pkg::t_dp_status i_status,
    output logic                o_in_ready,
    output bbs_pkg::t_dp_cmd    o_cmd
);

    localparam int CW = bbs_pkg::CNT_W;
    localparam logic [CW-1:0] SQR_LAST  = CW'(bbs_pkg::NUM_AXES);
    localparam logic [CW-1:0] ROOT_LAST = CW'(bbs_pkg::ROOT_STEPS - 1);

    bbs_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            r_fresh, n_fresh;
    logic            accept;

    assign accept = i_in_valid & o_in_ready;

    // State, step counter and start-of-mesh flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bbs_pkg::ST_ACCUM;
            r_cnt   <= '0;
            r_fresh <= 1'b1;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_fresh <= n_fresh;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            bbs_pkg::ST_ACCUM: begin
                if (accept && i_end_of_mesh) begin
                    n_state = bbs_pkg::ST_DIFF;
                end
            end
            bbs_pkg::ST_DIFF:  n_state = bbs_pkg::ST_SQR;
            bbs_pkg::ST_SQR: begin
                if (r_cnt == SQR_LAST) begin
                    n_state = bbs_pkg::ST_RINIT;
                end
            end
            bbs_pkg::ST_RINIT: n_state = bbs_pkg::ST_ROOT;
            bbs_pkg::ST_ROOT: begin
                if (r_cnt == ROOT_LAST) begin
                    n_state = bbs_pkg::ST_DONE;
                end
            end
            bbs_pkg::ST_DONE: begin
                if (!i_status.out_busy) begin
                    n_state = bbs_pkg::ST_ACCUM;
                end
            end
            default:           n_state = bbs_pkg::ST_ACCUM;
        endcase
    end

    // Counter and start-of-mesh flag
    always_comb begin
        n_fresh = r_fresh;
        if (accept) begin
            n_fresh = i_end_of_mesh;
        end
        case (r_state)
            bbs_pkg::ST_SQR,
            bbs_pkg::ST_ROOT: n_cnt = r_cnt + 1'b1;
            default:          n_cnt = '0;
        endcase
    end

    // Commands to the datapath
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            bbs_pkg::ST_ACCUM: begin
                o_in_ready      = 1'b1;
                o_cmd.box_load  = accept & r_fresh;
                o_cmd.box_track = accept & ~r_fresh;
            end
            bbs_pkg::ST_DIFF:  o_cmd.diff_en = 1'b1;
            bbs_pkg::ST_SQR: begin
                o_cmd.sq_en  = (r_cnt != SQR_LAST);
                o_cmd.acc_en = (r_cnt != '0);
                o_cmd.axis   = r_cnt[bbs_pkg::AXIS_W-1:0];
            end
            bbs_pkg::ST_RINIT: o_cmd.root_init = 1'b1;
            bbs_pkg::ST_ROOT:  o_cmd.root_step = 1'b1;
            bbs_pkg::ST_DONE:  o_cmd.out_load  = ~i_status.out_busy;
            default:           o_cmd = '0;
        endcase
    end

endmodule
